// ===== design/slbbs_pkg.sv =====
// Shared types and constants for the status LED blink and beep sequencer.
// No dependencies; slbbs_regs, slbbs_core and the top level import this package.
`default_nettype none

package slbbs_pkg;

    localparam int TICK_COUNTER_BITS_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 16;
    localparam int RPT_W     = 8;
    localparam int CD_W      = LEN_W + 1;

    localparam logic [CFG_W-1:0] SHOW_TICK_RESET    = 16'd2000;
    localparam logic [CFG_W-1:0] RESTORE_TICK_RESET = 16'd2100;

    localparam logic [LEN_W-1:0] BEEP_DEF_LENGTH = 16'd20;
    localparam logic [LEN_W-1:0] BEEP_DEF_PAUSE  = 16'd0;
    localparam logic [RPT_W-1:0] BEEP_DEF_REPEAT = 8'd1;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_BUZZ = 2'd1,
        ACT_BEEP = 2'd2
    } t_action;

    typedef enum logic {
        REG_SHOW_TICK    = 1'b0,
        REG_RESTORE_TICK = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] show_tick;
        logic [CFG_W-1:0] restore_tick;
    } t_cfg;

    typedef struct packed {
        logic red;
        logic green;
        logic buzzer;
    } t_levels;

endpackage

`default_nettype wire

// ===== design/slbbs_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing but the field widths listed here.
`default_nettype none

interface slbbs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        rf_enabled_0;
    logic        rf_enabled_1;
    logic [15:0] req_length;
    logic [15:0] req_pause;
    logic [7:0]  req_repeat;

    modport source (
        output valid, action, rf_enabled_0, rf_enabled_1, req_length, req_pause, req_repeat,
        input  ready
    );
    modport sink (
        input  valid, action, rf_enabled_0, rf_enabled_1, req_length, req_pause, req_repeat,
        output ready
    );
endinterface

interface slbbs_out_if;
    logic valid;
    logic ready;
    logic red_led;
    logic green_led;
    logic buzzer_on;

    modport source (
        output valid, red_led, green_led, buzzer_on,
        input  ready
    );
    modport sink (
        input  valid, red_led, green_led, buzzer_on,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/slbbs_regs.sv =====
// APB-style configuration registers: show tick and restore tick.
// Depends on slbbs_pkg.
`default_nettype none

module slbbs_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [slbbs_pkg::ADDR_W-1:0]  i_paddr,
    input  wire logic [slbbs_pkg::DATA_W-1:0]  i_pwdata,
    output      logic [slbbs_pkg::DATA_W-1:0]  o_prdata,
    output      slbbs_pkg::t_cfg               o_cfg
);
    import slbbs_pkg::*;

    logic [CFG_W-1:0] r_show;
    logic [CFG_W-1:0] r_restore;
    logic             wr_en;
    t_reg_idx         idx;

    assign wr_en = i_psel && i_penable && i_pwrite;
    assign idx   = t_reg_idx'(i_paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show    <= SHOW_TICK_RESET;
            r_restore <= RESTORE_TICK_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_SHOW_TICK:    r_show    <= i_pwdata[CFG_W-1:0];
                REG_RESTORE_TICK: r_restore <= i_pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SHOW_TICK:    o_prdata = DATA_W'(r_show);
            REG_RESTORE_TICK: o_prdata = DATA_W'(r_restore);
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg.show_tick    = r_show;
    assign o_cfg.restore_tick = r_restore;

endmodule

`default_nettype wire

// ===== design/slbbs_core.sv =====
// Sequencer state and its single-pass update: blink counter, LED levels and
// beep countdown. Depends on slbbs_pkg.
`default_nettype none

module slbbs_core #(
    parameter int TICK_COUNTER_BITS = slbbs_pkg::TICK_COUNTER_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire slbbs_pkg::t_cfg              i_cfg,
    input  wire logic [1:0]                   i_action,
    input  wire logic                         i_rf_enabled_0,
    input  wire logic                         i_rf_enabled_1,
    input  wire logic [slbbs_pkg::LEN_W-1:0]  i_req_length,
    input  wire logic [slbbs_pkg::LEN_W-1:0]  i_req_pause,
    input  wire logic [slbbs_pkg::RPT_W-1:0]  i_req_repeat,
    output      slbbs_pkg::t_levels           o_levels
);
    import slbbs_pkg::*;

    localparam int CNT_W = TICK_COUNTER_BITS;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CD_W-1:0]  r_cd, n_cd;
    logic [LEN_W-1:0] r_on_len, n_on_len;
    logic [LEN_W-1:0] r_off_len, n_off_len;
    logic [RPT_W-1:0] r_left, n_left;
    logic             r_red, n_red;
    logic             r_green, n_green;
    logic             r_buzz, n_buzz;

    logic [CNT_W-1:0] cnt_inc;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CD_W-1:0]  cd_dec;
    t_action          act;

    assign act     = t_action'(i_action);
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign cnt_cmp = CMP_W'(cnt_inc);
    assign cd_dec  = r_cd - CD_W'(1);

    always_comb begin
        n_cnt     = r_cnt;
        n_cd      = r_cd;
        n_on_len  = r_on_len;
        n_off_len = r_off_len;
        n_left    = r_left;
        n_red     = r_red;
        n_green   = r_green;
        n_buzz    = r_buzz;
        unique case (act)
            ACT_TICK: begin
                n_cnt = cnt_inc;
                // show check wins over restore when both match
                if (cnt_cmp == CMP_W'(i_cfg.show_tick)) begin
                    n_red   = !i_rf_enabled_0;
                    n_green = !i_rf_enabled_1;
                end else if (cnt_cmp == CMP_W'(i_cfg.restore_tick)) begin
                    n_red   = 1'b1;
                    n_green = 1'b1;
                    n_cnt   = '0;
                end
                if (r_cd == '0) begin
                    if (r_left != '0) begin
                        n_left = r_left - RPT_W'(1);
                        n_cd   = CD_W'(r_on_len) + CD_W'(r_off_len);
                        n_buzz = 1'b1;
                    end
                end else begin
                    n_cd = cd_dec;
                    if (cd_dec == CD_W'(r_off_len)) begin
                        n_buzz = 1'b0;
                    end
                end
            end
            ACT_BUZZ: begin
                n_on_len  = i_req_length;
                n_off_len = i_req_pause;
                n_left    = i_req_repeat;
            end
            ACT_BEEP: begin
                n_on_len  = BEEP_DEF_LENGTH;
                n_off_len = BEEP_DEF_PAUSE;
                n_left    = BEEP_DEF_REPEAT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cd      <= '0;
            r_on_len  <= '0;
            r_off_len <= '0;
            r_left    <= '0;
            r_red     <= 1'b1;
            r_green   <= 1'b1;
            r_buzz    <= 1'b0;
        end else if (i_en) begin
            r_cnt     <= n_cnt;
            r_cd      <= n_cd;
            r_on_len  <= n_on_len;
            r_off_len <= n_off_len;
            r_left    <= n_left;
            r_red     <= n_red;
            r_green   <= n_green;
            r_buzz    <= n_buzz;
        end
    end

    assign o_levels.red    = n_red;
    assign o_levels.green  = n_green;
    assign o_levels.buzzer = n_buzz;

endmodule

`default_nettype wire

// ===== design/status_led_blink_and_beep_sequencer_top.sv =====
// Status LED blink and beep sequencer, top level: input register, result
// register and configuration port. Depends on slbbs_pkg, slbbs_if,
// slbbs_regs and slbbs_core.
//
// Each accepted item (tick, buzz request or default beep request) yields one
// result with the red LED, green LED and buzzer levels after that item. An
// item is held in the input register, then updated in one pass through the
// sequencer state into the result register, where result valid rises; a
// result not yet taken holds the item in the input register, and one item
// is taken every cycle as long as the result side keeps up. The show and
// restore ticks are written through the APB port at byte addresses 0 and 4;
// the user must write them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module status_led_blink_and_beep_sequencer_top #(
    parameter int TICK_COUNTER_BITS = slbbs_pkg::TICK_COUNTER_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    slbbs_in_if.sink                           i_item,
    slbbs_out_if.source                        o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [slbbs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [slbbs_pkg::DATA_W-1:0]  pwdata,
    output      logic [slbbs_pkg::DATA_W-1:0]  prdata,
    output      logic                          pready
);
    import slbbs_pkg::*;

    t_cfg    cfg;
    t_levels levels;

    logic             r_in_valid;
    logic [1:0]       r_action;
    logic             r_rf0;
    logic             r_rf1;
    logic [LEN_W-1:0] r_length;
    logic [LEN_W-1:0] r_pause;
    logic [RPT_W-1:0] r_repeat;

    logic    r_out_valid;
    t_levels r_out;

    logic advance;
    logic in_ready;

    // move the held item into the result register when that slot frees up
    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_item.ready = in_ready;
    assign pready       = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_action <= i_item.action;
            r_rf0    <= i_item.rf_enabled_0;
            r_rf1    <= i_item.rf_enabled_1;
            r_length <= i_item.req_length;
            r_pause  <= i_item.req_pause;
            r_repeat <= i_item.req_repeat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= levels;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.red_led   = r_out.red;
    assign o_result.green_led = r_out.green;
    assign o_result.buzzer_on = r_out.buzzer;

    slbbs_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    slbbs_core #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_cfg          (cfg),
        .i_action       (r_action),
        .i_rf_enabled_0 (r_rf0),
        .i_rf_enabled_1 (r_rf1),
        .i_req_length   (r_length),
        .i_req_pause    (r_pause),
        .i_req_repeat   (r_repeat),
        .o_levels       (levels)
    );

endmodule

`default_nettype wire
